FILE: hw/rtl/vcsg_pkg.sv
// package for the velocity command safety gate
// command codes, configuration register indexes and fixed limits
// no dependencies
package vcsg_pkg;

  // item kinds carried on in_tuser
  localparam logic [1:0] CMD_VELOCITY = 2'd0;
  localparam logic [1:0] CMD_STOP     = 2'd1;
  localparam logic [1:0] CMD_SCALE    = 2'd2;
  localparam logic [1:0] CMD_TICK     = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_SAFE_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_TIMEOUT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOWDOWN_ENABLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SCALE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SCALE        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPUBLISH_PERIOD = 3'd5;

  // field widths
  localparam int unsigned VEL_WIDTH_DEF = 16;
  localparam int unsigned AGE_W         = 13;
  localparam int unsigned SCALE_W       = 16;
  localparam int unsigned SCALE_IN_W    = 17;
  localparam int unsigned PERIOD_W      = 10;

  // limits
  localparam logic [SCALE_W-1:0]  ONE_Q15     = 16'h8000;
  localparam logic [AGE_W-1:0]    AGE_MAX     = 13'd8191;
  localparam logic [AGE_W-1:0]    TIMEOUT_MIN = 13'd50;
  localparam logic [AGE_W-1:0]    TIMEOUT_MAX = 13'd5000;
  localparam logic [AGE_W-1:0]    TIMEOUT_RST = 13'd500;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN  = 10'd5;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX  = 10'd1000;

endpackage

FILE: hw/rtl/velocity_command_safety_gate_top.sv
// velocity command safety gate, top level
// single registered pass from an input stage to an output stage
// depends on vcsg_pkg
//
// usage
//   in_*  : one transaction per item; in_tuser is the item kind (velocity,
//           stop, slowdown factor, 1 ms tick), in_tdata carries the payload
//   out_* : gated three-axis velocity for the motor driver
//   cfg_* : register writes, taken on any edge with cfg_wr_en high
// an accepted item sits in the input register; its state update and result
//   are registered together when it leaves that register, and the result then
//   shows on out_*
// throughput: one item per cycle when not stalled; the multiply, clamps and
//   compares sit in one combinational pass between the two registers
// reset (rst_n low, synchronous): registers go to their documented defaults,
//   no command held, stop never seen (stale), scale 1.0, both stages empty
// stall: while out_tready is low and a result waits, a held input item stays
//   and in_tready is low; items that make no result also wait, order is kept
module velocity_command_safety_gate_top
  import vcsg_pkg::*;
#(
  parameter int unsigned VEL_WIDTH = VEL_WIDTH_DEF,
  localparam int unsigned IN_RAW_W  = 3 * VEL_WIDTH + 1 + SCALE_IN_W,
  localparam int unsigned IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8,
  localparam int unsigned OUT_RAW_W = 3 * VEL_WIDTH,
  localparam int unsigned OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // lin_x, lin_y, ang_z, stop_request, scale_in, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command
  input  logic [1:0]            in_tuser,
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_lin_x, out_lin_y, out_ang_z, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned PROD_W = VEL_WIDTH + SCALE_IN_W;

  // configuration registers
  logic                  fail_safe_r;
  logic [AGE_W-1:0]      timeout_r;
  logic                  slowdown_r;
  logic [SCALE_W-1:0]    min_scale_r;
  logic [SCALE_W-1:0]    max_scale_r;
  logic [PERIOD_W-1:0]   period_r;

  // input stage
  logic                  in_valid_r;
  logic [1:0]            in_cmd_r;
  logic [VEL_WIDTH-1:0]  in_lin_x_r;
  logic [VEL_WIDTH-1:0]  in_lin_y_r;
  logic [VEL_WIDTH-1:0]  in_ang_z_r;
  logic                  in_stop_r;
  logic [SCALE_IN_W-1:0] in_scale_r;

  // block state
  logic [VEL_WIDTH-1:0]  held_x_r, held_x_nxt;
  logic [VEL_WIDTH-1:0]  held_y_r, held_y_nxt;
  logic [VEL_WIDTH-1:0]  held_z_r, held_z_nxt;
  logic                  have_cmd_r, have_cmd_nxt;
  logic                  stop_active_r, stop_active_nxt;
  logic                  stop_seen_r, stop_seen_nxt;
  logic [AGE_W-1:0]      stop_age_r, stop_age_nxt;
  logic [SCALE_W-1:0]    cur_scale_r, cur_scale_nxt;
  logic [PERIOD_W-1:0]   rep_cnt_r, rep_cnt_nxt;

  // output stage
  logic                  out_valid_r;
  logic [OUT_RAW_W-1:0]  out_data_r;

  // combinational pass
  logic                  advance;
  logic                  emit;
  logic [AGE_W-1:0]      eff_timeout;
  logic [PERIOD_W-1:0]   eff_period;
  logic [SCALE_W-1:0]    bound_a, bound_b, scale_lo, scale_hi;
  logic [SCALE_W-1:0]    gate_scale;
  logic [PERIOD_W-1:0]   rep_cnt_inc;
  logic                  stale, zero_out;
  logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;
  logic [OUT_RAW_W-1:0]  result;

  // input stage moves on when the output slot is free or being emptied
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_safe_r <= 1'b1;
      timeout_r   <= TIMEOUT_RST;
      slowdown_r  <= 1'b1;
      min_scale_r <= '0;
      max_scale_r <= ONE_Q15;
      period_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_FAIL_SAFE_ENABLE: fail_safe_r <= cfg_wdata[0];
        REG_STALE_TIMEOUT:    timeout_r   <= cfg_wdata[AGE_W-1:0];
        REG_SLOWDOWN_ENABLE:  slowdown_r  <= cfg_wdata[0];
        REG_MIN_SCALE:        min_scale_r <= cfg_wdata[SCALE_W-1:0];
        REG_MAX_SCALE:        max_scale_r <= cfg_wdata[SCALE_W-1:0];
        REG_REPUBLISH_PERIOD: period_r    <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_cmd_r   <= in_tuser;
      in_lin_x_r <= in_tdata[VEL_WIDTH-1:0];
      in_lin_y_r <= in_tdata[2*VEL_WIDTH-1:VEL_WIDTH];
      in_ang_z_r <= in_tdata[3*VEL_WIDTH-1:2*VEL_WIDTH];
      in_stop_r  <= in_tdata[3*VEL_WIDTH];
      in_scale_r <= in_tdata[3*VEL_WIDTH+SCALE_IN_W:3*VEL_WIDTH+1];
    end
  end

  // effective limits from the registers
  always_comb begin
    if (timeout_r < TIMEOUT_MIN) begin
      eff_timeout = TIMEOUT_MIN;
    end else if (timeout_r > TIMEOUT_MAX) begin
      eff_timeout = TIMEOUT_MAX;
    end else begin
      eff_timeout = timeout_r;
    end

    // zero keeps republish off; short and long periods are pulled into range
    if (period_r == '0) begin
      eff_period = '0;
    end else if (period_r < PERIOD_MIN) begin
      eff_period = PERIOD_MIN;
    end else if (period_r > PERIOD_MAX) begin
      eff_period = PERIOD_MAX;
    end else begin
      eff_period = period_r;
    end

    // scale bounds capped at 1.0 and put in order
    bound_a = (min_scale_r > ONE_Q15) ? ONE_Q15 : min_scale_r;
    bound_b = (max_scale_r > ONE_Q15) ? ONE_Q15 : max_scale_r;
    if (bound_a > bound_b) begin
      scale_lo = bound_b;
      scale_hi = bound_a;
    end else begin
      scale_lo = bound_a;
      scale_hi = bound_b;
    end
  end

  // next state and emit decision for the item in the input stage
  always_comb begin
    held_x_nxt      = held_x_r;
    held_y_nxt      = held_y_r;
    held_z_nxt      = held_z_r;
    have_cmd_nxt    = have_cmd_r;
    stop_active_nxt = stop_active_r;
    stop_seen_nxt   = stop_seen_r;
    stop_age_nxt    = stop_age_r;
    cur_scale_nxt   = cur_scale_r;
    rep_cnt_nxt     = rep_cnt_r;
    rep_cnt_inc     = rep_cnt_r + 1'b1;
    emit            = 1'b0;

    case (in_cmd_r)
      CMD_VELOCITY: begin
        held_x_nxt   = in_lin_x_r;
        held_y_nxt   = in_lin_y_r;
        held_z_nxt   = in_ang_z_r;
        have_cmd_nxt = 1'b1;
        emit         = (eff_period == '0);
      end
      CMD_STOP: begin
        // an asserted stop zeroes the gate below, so the result is all zero
        stop_active_nxt = in_stop_r;
        stop_seen_nxt   = 1'b1;
        stop_age_nxt    = '0;
        emit            = in_stop_r;
      end
      CMD_SCALE: begin
        // lower bound is never negative, so the clamp lands in 0..1.0
        if ($signed(in_scale_r) < $signed({1'b0, scale_lo})) begin
          cur_scale_nxt = scale_lo;
        end else if ($signed(in_scale_r) > $signed({1'b0, scale_hi})) begin
          cur_scale_nxt = scale_hi;
        end else begin
          cur_scale_nxt = in_scale_r[SCALE_W-1:0];
        end
      end
      CMD_TICK: begin
        if (stop_age_r != AGE_MAX) begin
          stop_age_nxt = stop_age_r + 1'b1;
        end
        if (eff_period != '0) begin
          if (rep_cnt_inc >= eff_period) begin
            rep_cnt_nxt = '0;
            emit        = have_cmd_r;
          end else begin
            rep_cnt_nxt = rep_cnt_inc;
          end
        end
      end
      default: ;
    endcase
  end

  // gate on the updated state
  always_comb begin
    if (cur_scale_nxt < scale_lo) begin
      gate_scale = scale_lo;
    end else if (cur_scale_nxt > scale_hi) begin
      gate_scale = scale_hi;
    end else begin
      gate_scale = cur_scale_nxt;
    end

    stale    = !stop_seen_nxt || (stop_age_nxt > eff_timeout);
    zero_out = (fail_safe_r && stale) || stop_active_nxt;

    prod_x = $signed(held_x_nxt) * $signed({1'b0, gate_scale});
    prod_y = $signed(held_y_nxt) * $signed({1'b0, gate_scale});
    prod_z = $signed(held_z_nxt) * $signed({1'b0, gate_scale});

    if (zero_out) begin
      result = '0;
    end else if (slowdown_r) begin
      // arithmetic shift right by 15, floor rounding
      result = {prod_z[VEL_WIDTH+14:15], prod_y[VEL_WIDTH+14:15],
                prod_x[VEL_WIDTH+14:15]};
    end else begin
      result = {held_z_nxt, held_y_nxt, held_x_nxt};
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_x_r      <= '0;
      held_y_r      <= '0;
      held_z_r      <= '0;
      have_cmd_r    <= 1'b0;
      stop_active_r <= 1'b0;
      stop_seen_r   <= 1'b0;
      stop_age_r    <= '0;
      cur_scale_r   <= ONE_Q15;
      rep_cnt_r     <= '0;
    end else if (advance) begin
      held_x_r      <= held_x_nxt;
      held_y_r      <= held_y_nxt;
      held_z_r      <= held_z_nxt;
      have_cmd_r    <= have_cmd_nxt;
      stop_active_r <= stop_active_nxt;
      stop_seen_r   <= stop_seen_nxt;
      stop_age_r    <= stop_age_nxt;
      cur_scale_r   <= cur_scale_nxt;
      rep_cnt_r     <= rep_cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);

endmodule

FILE: sim/vcsg_output_checker.sv
// result checker for the velocity command safety gate
// watches the input, result and register write ports, predicts the gated output
// and compares it field by field; depends on vcsg_pkg
module vcsg_output_checker
  import vcsg_pkg::*;
#(
  parameter int unsigned IN_DATA_W  = 72,
  parameter int unsigned OUT_DATA_W = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]            in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    results_seen
);

  // lin_x sits in the lowest bits, as on the result port
  typedef struct packed {
    logic signed [15:0] ang_z;
    logic signed [15:0] lin_y;
    logic signed [15:0] lin_x;
  } axes_t;

  // register copies
  logic        fail_safe_q;
  logic [12:0] timeout_q;
  logic        slowdown_q;
  logic [15:0] min_scale_q;
  logic [15:0] max_scale_q;
  logic [9:0]  period_q;

  // gate state
  axes_t       held_cmd;
  logic        have_cmd;
  logic        stop_on;
  logic        stop_seen;
  logic [12:0] stop_age;
  int          cur_scale;
  logic [9:0]  republish_cnt;

  axes_t gated_results_q[$];

  function automatic void scale_limits(output int lo, output int hi);
    int a;
    int b;
    a = (min_scale_q > ONE_Q15) ? int'(ONE_Q15) : int'(min_scale_q);
    b = (max_scale_q > ONE_Q15) ? int'(ONE_Q15) : int'(max_scale_q);
    lo = (a > b) ? b : a;
    hi = (a > b) ? a : b;
  endfunction

  function automatic int clamp_to_limits(int s);
    int lo;
    int hi;
    scale_limits(lo, hi);
    if (s < lo) return lo;
    if (s > hi) return hi;
    return s;
  endfunction

  function automatic int timeout_eff();
    if (timeout_q < TIMEOUT_MIN) return int'(TIMEOUT_MIN);
    if (timeout_q > TIMEOUT_MAX) return int'(TIMEOUT_MAX);
    return int'(timeout_q);
  endfunction

  function automatic int period_eff();
    if (period_q == '0) return 0;
    if (period_q < PERIOD_MIN) return int'(PERIOD_MIN);
    if (period_q > PERIOD_MAX) return int'(PERIOD_MAX);
    return int'(period_q);
  endfunction

  // v * s with an arithmetic shift by 15, so it rounds toward minus infinity
  function automatic logic [15:0] apply_scale(logic signed [15:0] v, int s);
    logic signed [33:0] sv;
    logic signed [33:0] prod;
    sv = s;
    prod = v * sv;
    return prod[30:15];
  endfunction

  function automatic axes_t gated_output();
    axes_t r;
    logic  stale;
    int    s;
    r = '0;
    stale = !stop_seen || (stop_age > timeout_eff());
    if ((fail_safe_q && stale) || stop_on) return r;
    if (slowdown_q) begin
      s = clamp_to_limits(cur_scale);
      r.lin_x = apply_scale(held_cmd.lin_x, s);
      r.lin_y = apply_scale(held_cmd.lin_y, s);
      r.ang_z = apply_scale(held_cmd.ang_z, s);
    end else begin
      r = held_cmd;
    end
    return r;
  endfunction

  task automatic reset_model();
    fail_safe_q   = 1'b1;
    timeout_q     = TIMEOUT_RST;
    slowdown_q    = 1'b1;
    min_scale_q   = '0;
    max_scale_q   = ONE_Q15;
    period_q      = '0;
    held_cmd      = '0;
    have_cmd      = 1'b0;
    stop_on       = 1'b0;
    stop_seen     = 1'b0;
    stop_age      = '0;
    cur_scale     = int'(ONE_Q15);
    republish_cnt = '0;
    gated_results_q.delete();
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_FAIL_SAFE_ENABLE: fail_safe_q = val[0];
      REG_STALE_TIMEOUT:    timeout_q   = val[12:0];
      REG_SLOWDOWN_ENABLE:  slowdown_q  = val[0];
      REG_MIN_SCALE:        min_scale_q = val[15:0];
      REG_MAX_SCALE:        max_scale_q = val[15:0];
      REG_REPUBLISH_PERIOD: period_q    = val[9:0];
      default: ;
    endcase
  endtask

  task automatic predict_item(logic [1:0] kind, logic [IN_DATA_W-1:0] payload);
    int per;
    per = period_eff();
    case (kind)
      CMD_VELOCITY: begin
        held_cmd = payload[47:0];
        have_cmd = 1'b1;
        if (per == 0) gated_results_q.push_back(gated_output());
      end
      CMD_STOP: begin
        stop_on   = payload[48];
        stop_seen = 1'b1;
        stop_age  = '0;
        if (stop_on) gated_results_q.push_back('0);
      end
      CMD_SCALE: begin
        cur_scale = clamp_to_limits(int'($signed(payload[65:49])));
      end
      CMD_TICK: begin
        if (stop_age < AGE_MAX) stop_age = stop_age + 1'b1;
        if (per != 0) begin
          republish_cnt = republish_cnt + 1'b1;
          if (republish_cnt >= per) begin
            republish_cnt = '0;
            if (have_cmd) gated_results_q.push_back(gated_output());
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result(axes_t got);
    axes_t want;
    results_seen++;
    if (gated_results_q.size() == 0) begin
      $error("result with nothing expected: lin_x %0d lin_y %0d ang_z %0d",
             got.lin_x, got.lin_y, got.ang_z);
      fail_count++;
      return;
    end
    want = gated_results_q.pop_front();
    if (got.lin_x !== want.lin_x) begin
      $error("out_lin_x mismatch: expected %0d, got %0d", want.lin_x, got.lin_x);
      fail_count++;
    end
    if (got.lin_y !== want.lin_y) begin
      $error("out_lin_y mismatch: expected %0d, got %0d", want.lin_y, got.lin_y);
      fail_count++;
    end
    if (got.ang_z !== want.ang_z) begin
      $error("out_ang_z mismatch: expected %0d, got %0d", want.ang_z, got.ang_z);
      fail_count++;
    end
  endtask

  initial begin
    fail_count   = 0;
    results_seen = 0;
    pending      = 0;
    reset_model();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_wr_en) write_register(cfg_addr, cfg_wdata);
      if (out_tvalid && out_tready) check_result(out_tdata[47:0]);
      if (in_tvalid && in_tready) predict_item(in_tuser, in_tdata);
    end
    pending = gated_results_q.size();
  end

endmodule

FILE: sim/velocity_command_safety_gate_top_tb.sv
// testbench top for the velocity command safety gate
// drives items and register writes, randomizes idling on both channels and
// reports the verdict; depends on vcsg_pkg and vcsg_output_checker
module velocity_command_safety_gate_top_tb;
  import vcsg_pkg::*;

  localparam int unsigned VW         = VEL_WIDTH_DEF;
  localparam int unsigned IN_DATA_W  = ((3 * VW + 1 + SCALE_IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((3 * VW + 7) / 8) * 8;
  // two register stages; spare drain time covers items that make no result
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_OFF_LEN  = 120;
  localparam int PHASE_ITEMS   = 26;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // lin_x, lin_y, ang_z, stop_request, scale_in, zero fill
  logic [IN_DATA_W-1:0]  in_tdata;
  // command
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // out_lin_x, out_lin_y, out_ang_z
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_cnt;
  int pending_cnt;
  int results_cnt;

  // idling knobs, percent of cycles
  int tx_idle_pct;
  int rx_idle_pct;
  int long_stall_reqs;
  int items_sent;
  int cfg_loads;

  velocity_command_safety_gate_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  vcsg_output_checker #(
    .IN_DATA_W  (IN_DATA_W),
    .OUT_DATA_W (OUT_DATA_W)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_cnt),
    .pending      (pending_cnt),
    .results_seen (results_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(12 * 1000000);
    $display("run stopped by the watchdog, %0d results still expected", pending_cnt);
    $display("== FAIL ==");
    $finish;
  end

  // receiver: random back-pressure, plus one long hold-off per request so the
  // block fills both stages and drops in_tready
  initial begin : receiver
    int stall_left;
    int stalls_done;
    stall_left  = 0;
    stalls_done = 0;
    out_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_reqs != stalls_done && stall_left == 0) begin
        stall_left = HOLD_OFF_LEN;
        stalls_done++;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // all payload fields random; callers overwrite the one the kind uses
  function automatic logic [IN_DATA_W-1:0] rand_payload();
    logic [IN_DATA_W-1:0] p;
    p = '0;
    p[31:0]  = $urandom;
    p[63:32] = $urandom;
    p[65:64] = 2'($urandom_range(3));
    return p;
  endfunction

  function automatic logic [15:0] rand_vel();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] rand_scale_in();
    case ($urandom_range(8))
      0:       return 17'h10000;
      1:       return 17'h0ffff;
      2:       return 17'd32768;
      3:       return 17'd32769;
      4:       return 17'h1ffff;
      5:       return 17'd0;
      6:       return 17'($urandom);
      default: return 17'($urandom_range(32768));
    endcase
  endfunction

  // one input transaction; starts and ends on a falling edge, in_tvalid is
  // left high so back-to-back items need no extra edge
  task automatic send_item(logic [1:0] kind, logic [IN_DATA_W-1:0] payload);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= payload;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_velocity(logic [15:0] lx, logic [15:0] ly, logic [15:0] az);
    logic [IN_DATA_W-1:0] p;
    p = rand_payload();
    p[47:0] = {az, ly, lx};
    send_item(CMD_VELOCITY, p);
  endtask

  task automatic send_stop(logic req);
    logic [IN_DATA_W-1:0] p;
    p = rand_payload();
    p[48] = req;
    send_item(CMD_STOP, p);
  endtask

  task automatic send_scale(logic [16:0] s);
    logic [IN_DATA_W-1:0] p;
    p = rand_payload();
    p[65:49] = s;
    send_item(CMD_SCALE, p);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(CMD_TICK, rand_payload());
  endtask

  // stop offering, wait for every expected result, then let in-flight items
  // that make no result leave the pipeline
  task automatic settle();
    in_tvalid <= 1'b0;
    wait (pending_cnt == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  // every register is rewritten on each load, only while the block is idle
  task automatic load_config(logic fs, logic [12:0] tmo, logic sd, logic [15:0] mn,
                             logic [15:0] mx, logic [9:0] per);
    cfg_write(REG_FAIL_SAFE_ENABLE, CFG_DATA_W'(fs));
    cfg_write(REG_STALE_TIMEOUT,    CFG_DATA_W'(tmo));
    cfg_write(REG_SLOWDOWN_ENABLE,  CFG_DATA_W'(sd));
    cfg_write(REG_MIN_SCALE,        mn);
    cfg_write(REG_MAX_SCALE,        mx);
    cfg_write(REG_REPUBLISH_PERIOD, CFG_DATA_W'(per));
    cfg_wr_en <= 1'b0;
    cfg_loads++;
  endtask

  task automatic load_random_config();
    logic [12:0] tmo;
    logic [15:0] mn;
    logic [15:0] mx;
    logic [9:0]  per;
    case ($urandom_range(7))
      0: tmo = 13'd0;
      1: tmo = 13'd49;
      2: tmo = 13'd50;
      3: tmo = 13'd51;
      4: tmo = 13'd5000;
      5: tmo = 13'd8191;
      6: tmo = 13'($urandom);
      default: tmo = 13'($urandom_range(50, 200));
    endcase
    case ($urandom_range(4))
      0: mn = 16'd0;
      1: mn = 16'hffff;
      2: mn = 16'($urandom);
      default: mn = 16'($urandom_range(32768));
    endcase
    case ($urandom_range(4))
      0: mx = 16'd32768;
      1: mx = 16'd0;
      2: mx = 16'($urandom);
      default: mx = 16'($urandom_range(32768));
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3: per = 10'd0;
      4: per = 10'($urandom_range(1, 4));
      5: per = 10'd5;
      6: per = 10'd1023;
      7: per = 10'($urandom);
      default: per = 10'($urandom_range(5, 20));
    endcase
    load_config(1'($urandom_range(1)), tmo, $urandom_range(99) < 75, mn, mx, per);
  endtask

  // mostly commands and ticks with random content, now and then a long tick
  // run that can age the stop signal past a short timeout
  task automatic run_random(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 35)
        send_velocity(rand_vel(), rand_vel(), rand_vel());
      else if (r < 50)
        send_stop($urandom_range(99) < 30);
      else if (r < 62)
        send_scale(rand_scale_in());
      else if (r < 97)
        send_ticks(1);
      else
        send_ticks($urandom_range(40, 120));
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tuser        = CMD_VELOCITY;
    cfg_wr_en       = 1'b0;
    cfg_addr        = REG_FAIL_SAFE_ENABLE;
    cfg_wdata       = '0;
    tx_idle_pct     = 0;
    rx_idle_pct     = 0;
    long_stall_reqs = 0;
    items_sent      = 0;
    cfg_loads       = 0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed part, reset register values first ----
    // no stop signal received yet, so the command is zeroed
    send_velocity(16'd1000, 16'hfc18, 16'd7);
    send_stop(1'b0);
    // field extremes at scale 1.0
    send_velocity(16'h7fff, 16'h8000, 16'h0000);
    send_velocity(16'hffff, 16'h0001, 16'h8000);
    // most negative factor clamps to the lower bound of zero
    send_scale(17'h10000);
    send_velocity(16'h7fff, 16'h8000, 16'h1234);
    // largest factor clamps to 1.0, then half scale rounds toward minus infinity
    send_scale(17'h0ffff);
    send_scale(17'd16384);
    send_velocity(16'hfffd, 16'h0003, 16'h8000);
    // stop asserted: zero at once and zero for the next command
    send_stop(1'b1);
    send_velocity(16'h7fff, 16'h7fff, 16'h7fff);
    send_stop(1'b0);
    settle();

    // timeout below range acts as 50, short period acts as 5, bounds given in
    // the wrong order get swapped
    load_config(1'b1, 13'd0, 1'b1, 16'd30000, 16'd10000, 10'd3);
    send_scale(17'd32768);
    send_velocity(16'h7fff, 16'h8000, 16'hc000);
    send_ticks(5);
    // age runs past the clamped timeout, the last republish comes out zeroed
    send_ticks(51);
    send_stop(1'b0);
    settle();

    // timeout, period and min above range; max below min
    load_config(1'b0, 13'd8191, 1'b1, 16'hffff, 16'h0000, 10'd1023);
    send_velocity(16'h8001, 16'h0100, 16'hff00);
    send_ticks(10);
    settle();

    // period lowered below the running count fires on the next tick; the held
    // scale gets clamped again to the new upper bound
    load_config(1'b0, 13'd8191, 1'b1, 16'd0, 16'd8000, 10'd5);
    send_ticks(3);
    settle();

    // republish off keeps the count, slowdown off passes the command raw
    load_config(1'b0, 13'd50, 1'b0, 16'd32768, 16'd32768, 10'd0);
    send_ticks(3);
    send_velocity(16'h8000, 16'h7fff, 16'h0001);
    settle();

    // republish back on: the held count completes the period
    load_config(1'b1, 13'd500, 1'b1, 16'd0, 16'd32768, 10'd5);
    send_ticks(3);
    settle();

    // ---- random part, three idling modes ----
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          tx_idle_pct = 36;
          rx_idle_pct = 70;
        end
        1: begin
          tx_idle_pct = 70;
          rx_idle_pct = 36;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase

      if (mode == 2) begin
        // long receiver hold-off while commands keep coming; then the sender
        // waits for every result before going on
        settle();
        load_config(1'b1, 13'd5000, 1'b1, 16'd0, 16'd32768, 10'd0);
        send_stop(1'b0);
        long_stall_reqs++;
        repeat (16) send_velocity(rand_vel(), rand_vel(), rand_vel());
        settle();
      end

      repeat (3) begin
        settle();
        load_random_config();
        run_random(PHASE_ITEMS);
      end
    end

    settle();
    $display("sent %0d input transactions under %0d register settings", items_sent, cfg_loads);
    $display("checked %0d gated results, %0d failures", results_cnt, fail_cnt);
    if (fail_cnt == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/vcsg_pkg.sv
hw/rtl/velocity_command_safety_gate_top.sv
sim/vcsg_output_checker.sv
sim/velocity_command_safety_gate_top_tb.sv
